>>> design/blinn_phong_vertex_shade_assert.svh
// Assertion macros for the vertex shader
`ifndef BLINN_PHONG_VERTEX_SHADE_ASSERT_SVH
`define BLINN_PHONG_VERTEX_SHADE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPVS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPVS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPVS_ASSERT(lbl, prop, msg)
`define BPVS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> design/bpvs_pkg.sv
package bpvs_pkg;

    localparam int DEFAULT_NORMAL_WIDTH = 16;
    localparam int GAIN_W     = 16;
    localparam int SHINE_W    = 8;
    localparam int FRAC_BITS  = 28;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int C_W        = 15;
    localparam int ROOT_W     = 30;
    localparam int SQRT_STEPS = 15;
    localparam int POW_STEPS  = (1 << SHINE_W) - 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [C_W-1:0] ONE_Q14     = C_W'(16384);
    localparam logic [13:0]    HALF_Q14    = 14'd8192;

    localparam logic [GAIN_W-1:0]  AMBIENT_RST  = 16'd655;
    localparam logic [GAIN_W-1:0]  DIFFUSE_RST  = 16'd13107;
    localparam logic [GAIN_W-1:0]  SPECULAR_RST = 16'd16384;
    localparam logic [SHINE_W-1:0] SHINE_RST    = 8'd50;

    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPECULAR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHINE    = 2'd3;

    typedef struct packed {
        logic vld;
        logic face;
    } ctl_t;

endpackage

>>> design/bpvs_div.sv
module bpvs_div #(
    parameter int DW = 2 * bpvs_pkg::DEFAULT_NORMAL_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  bpvs_pkg::ctl_t             in_ctl,
    input  logic [DW-1:0]              in_num,
    input  logic [DW-1:0]              in_den,
    output bpvs_pkg::ctl_t             out_ctl,
    output logic [bpvs_pkg::Q_W-1:0]   out_q
);

    localparam int N = bpvs_pkg::FRAC_BITS;

    bpvs_pkg::ctl_t ctl_reg [N];
    logic [DW:0]    rem_reg [N];
    logic [DW-1:0]  den_reg [N];
    logic [N-1:0]   quo_reg [N];
    logic           full_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        bpvs_pkg::ctl_t ctl_in;
        logic [DW:0]    rem_in;
        logic [DW-1:0]  den_in;
        logic [N-1:0]   quo_in;
        logic           full_in;
        logic [DW:0]    shifted;
        logic           ge;

        if (k == 0) begin : g_first
            assign ctl_in  = in_ctl;
            assign rem_in  = {1'b0, in_num};
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign full_in = (in_num >= in_den);
        end else begin : g_next
            assign ctl_in  = ctl_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign full_in = full_reg[k-1];
        end

        assign shifted = {rem_in[DW-1:0], 1'b0};
        assign ge      = (shifted >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (advance)
            begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= ge ? (shifted - {1'b0, den_in}) : shifted;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= {quo_in[N-2:0], ge};
                full_reg[k] <= full_in;
            end
        end
    end

    assign out_ctl = ctl_reg[N-1];
    assign out_q   = full_reg[N-1] ? {1'b1, {N{1'b0}}} : {1'b0, quo_reg[N-1]};

endmodule

>>> design/bpvs_pow.sv
module bpvs_pow (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [bpvs_pkg::SHINE_W-1:0]     shine,
    input  bpvs_pkg::ctl_t                   in_ctl,
    input  logic [bpvs_pkg::C_W-1:0]         in_c,
    input  logic [bpvs_pkg::GAIN_W-1:0]      in_dif,
    output bpvs_pkg::ctl_t                   out_ctl,
    output logic [bpvs_pkg::C_W-1:0]         out_p,
    output logic [bpvs_pkg::GAIN_W-1:0]      out_dif
);

    localparam int N  = bpvs_pkg::POW_STEPS;
    localparam int CW = bpvs_pkg::C_W;

    bpvs_pkg::ctl_t              ctl_reg [N];
    logic [CW-1:0]               p_reg   [N];
    logic [CW-1:0]               c_reg   [N];
    logic [bpvs_pkg::GAIN_W-1:0] dif_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        bpvs_pkg::ctl_t              ctl_in;
        logic [CW-1:0]               p_in;
        logic [CW-1:0]               c_in;
        logic [bpvs_pkg::GAIN_W-1:0] dif_in;
        logic [2*CW-1:0]             prod;

        if (k == 0) begin : g_first
            assign ctl_in = in_ctl;
            assign p_in   = bpvs_pkg::ONE_Q14;
            assign c_in   = in_c;
            assign dif_in = in_dif;
        end else begin : g_next
            assign ctl_in = ctl_reg[k-1];
            assign p_in   = p_reg[k-1];
            assign c_in   = c_reg[k-1];
            assign dif_in = dif_reg[k-1];
        end

        assign prod = (2*CW)'(p_in) * (2*CW)'(c_in) + (2*CW)'(bpvs_pkg::HALF_Q14);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (advance)
            begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                p_reg[k]   <= (bpvs_pkg::SHINE_W'(k) < shine) ? prod[CW+13:14] : p_in;
                c_reg[k]   <= c_in;
                dif_reg[k] <= dif_in;
            end
        end
    end

    assign out_ctl = ctl_reg[N-1];
    assign out_p   = p_reg[N-1];
    assign out_dif = dif_reg[N-1];

endmodule

>>> design/blinn_phong_vertex_shade.sv
// Pipeline stages in order: squares, sum, divide, root, diffuse, power, specular,
// output. Throughput: one vertex per cycle unless a valid output waits on
// m_tready; every stage is a register and all advance together.
// rst_n clears valid bits and loads register defaults; no clearing pass.
module blinn_phong_vertex_shade #(
    parameter int NORMAL_WIDTH = bpvs_pkg::DEFAULT_NORMAL_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // normal_x, normal_y, normal_z
    input  logic [((3*NORMAL_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // intensity
    output logic [15:0]                        m_tdata,
    // faces_light
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [bpvs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpvs_pkg::GAIN_W-1:0]        cfg_data
);

    `include "blinn_phong_vertex_shade_assert.svh"

    localparam int NW = NORMAL_WIDTH;
    localparam int DW = 2 * NORMAL_WIDTH;
    localparam int GW = bpvs_pkg::GAIN_W;
    localparam int CW = bpvs_pkg::C_W;
    localparam int RW = bpvs_pkg::ROOT_W;
    localparam int SN = bpvs_pkg::SQRT_STEPS;

    logic [GW-1:0]               amb_reg, dg_reg, sg_reg;
    logic [bpvs_pkg::SHINE_W-1:0] shine_reg;
    logic                        advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amb_reg   <= bpvs_pkg::AMBIENT_RST;
            dg_reg    <= bpvs_pkg::DIFFUSE_RST;
            sg_reg    <= bpvs_pkg::SPECULAR_RST;
            shine_reg <= bpvs_pkg::SHINE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpvs_pkg::REG_AMBIENT:  amb_reg   <= cfg_data;
                bpvs_pkg::REG_DIFFUSE:  dg_reg    <= cfg_data;
                bpvs_pkg::REG_SPECULAR: sg_reg    <= cfg_data;
                bpvs_pkg::REG_SHINE:    shine_reg <= cfg_data[bpvs_pkg::SHINE_W-1:0];
                default:                amb_reg   <= amb_reg;
            endcase
        end
    end

    bpvs_pkg::ctl_t out_ctl_reg;
    assign advance  = !out_ctl_reg.vld || m_tready;
    assign s_tready = advance;

    // squares
    logic [NW-1:0] x_raw, y_raw, z_raw, x_mag, y_mag, z_mag;
    assign x_raw = s_tdata[NW-1:0];
    assign y_raw = s_tdata[2*NW-1:NW];
    assign z_raw = s_tdata[3*NW-1:2*NW];
    assign x_mag = x_raw[NW-1] ? (~x_raw + 1'b1) : x_raw;
    assign y_mag = y_raw[NW-1] ? (~y_raw + 1'b1) : y_raw;
    assign z_mag = z_raw[NW-1] ? (~z_raw + 1'b1) : z_raw;

    bpvs_pkg::ctl_t sq_ctl_reg, sum_ctl_reg;
    logic [DW-1:0]  sx_reg, sy_reg, sz_reg, s_reg, num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ctl_reg  <= '0;
            sum_ctl_reg <= '0;
        end
        else if (advance)
        begin
            sq_ctl_reg.vld  <= s_tvalid;
            sq_ctl_reg.face <= !z_raw[NW-1] && (z_raw != '0);
            sum_ctl_reg     <= sq_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sx_reg  <= DW'(x_mag) * DW'(x_mag);
            sy_reg  <= DW'(y_mag) * DW'(y_mag);
            sz_reg  <= DW'(z_mag) * DW'(z_mag);
            s_reg   <= sx_reg + sy_reg + sz_reg;
            num_reg <= sz_reg;
        end
    end

    bpvs_pkg::ctl_t           div_ctl;
    logic [bpvs_pkg::Q_W-1:0] div_q;

    bpvs_div #(.DW(DW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_ctl  (sum_ctl_reg),
        .in_num  (num_reg),
        .in_den  (s_reg),
        .out_ctl (div_ctl),
        .out_q   (div_q)
    );

    // integer square root, one result bit per stage
    bpvs_pkg::ctl_t rt_ctl_reg [SN];
    logic [RW-1:0]  rv_reg [SN];
    logic [RW-1:0]  rr_reg [SN];

    for (genvar k = 0; k < SN; k++) begin : g_root
        localparam logic [RW-1:0] BITV = RW'(1) << (28 - 2*k);
        bpvs_pkg::ctl_t ctl_in;
        logic [RW-1:0]  v_in, r_in, trial;

        if (k == 0) begin : g_first
            assign ctl_in = div_ctl;
            assign v_in   = RW'(div_q);
            assign r_in   = '0;
        end else begin : g_next
            assign ctl_in = rt_ctl_reg[k-1];
            assign v_in   = rv_reg[k-1];
            assign r_in   = rr_reg[k-1];
        end

        assign trial = r_in + BITV;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_ctl_reg[k] <= '0;
            end
            else if (advance)
            begin
                rt_ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (v_in >= trial)
                begin
                    rv_reg[k] <= v_in - trial;
                    rr_reg[k] <= (r_in >> 1) + BITV;
                end
                else
                begin
                    rv_reg[k] <= v_in;
                    rr_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    // diffuse term
    bpvs_pkg::ctl_t dif_ctl_reg;
    logic [CW-1:0]  c_reg;
    logic [GW-1:0]  dif_reg;
    logic [CW-1:0]  cos_w;
    logic [30:0]    dif_prod;

    assign cos_w    = rr_reg[SN-1][CW-1:0];
    assign dif_prod = 31'(dg_reg) * 31'(cos_w) + 31'(bpvs_pkg::HALF_Q14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dif_ctl_reg <= '0;
        end
        else if (advance)
        begin
            dif_ctl_reg <= rt_ctl_reg[SN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg   <= cos_w;
            dif_reg <= dif_prod[29:14];
        end
    end

    bpvs_pkg::ctl_t pow_ctl;
    logic [CW-1:0]  pow_p;
    logic [GW-1:0]  pow_dif;

    bpvs_pow u_pow (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .shine   (shine_reg),
        .in_ctl  (dif_ctl_reg),
        .in_c    (c_reg),
        .in_dif  (dif_reg),
        .out_ctl (pow_ctl),
        .out_p   (pow_p),
        .out_dif (pow_dif)
    );

    // specular term, then sum and saturate; ambient only when not facing the light
    bpvs_pkg::ctl_t spec_ctl_reg;
    logic [GW-1:0]  spec_reg, dif2_reg, out_reg;
    logic [30:0]    spec_prod;
    logic [GW+1:0]  total;

    assign spec_prod = 31'(sg_reg) * 31'(pow_p) + 31'(bpvs_pkg::HALF_Q14);
    assign total     = (GW+2)'(amb_reg) + (GW+2)'(dif2_reg) + (GW+2)'(spec_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spec_ctl_reg <= '0;
            out_ctl_reg  <= '0;
        end
        else if (advance)
        begin
            spec_ctl_reg <= pow_ctl;
            out_ctl_reg  <= spec_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            spec_reg <= spec_prod[29:14];
            dif2_reg <= pow_dif;
            if (!spec_ctl_reg.face)
            begin
                out_reg <= amb_reg;
            end
            else if (total[GW+1:GW] != 2'b00)
            begin
                out_reg <= '1;
            end
            else
            begin
                out_reg <= total[GW-1:0];
            end
        end
    end

    assign m_tvalid = out_ctl_reg.vld;
    assign m_tuser  = out_ctl_reg.face;
    assign m_tdata  = out_reg;

    `BPVS_ASSERT(a_away_ambient, m_tvalid && !m_tuser |-> m_tdata == amb_reg, "away not ambient")
    `BPVS_ASSERT(a_lit_floor, m_tvalid && m_tuser |-> m_tdata >= amb_reg, "lit below ambient")
    `BPVS_ASSERT_RST(a_rst_idle, !rst_n |-> !m_tvalid, "valid in reset")

endmodule

>>> tb/blinn_phong_vertex_shade_tb.sv
`timescale 1ns / 1ps

module blinn_phong_vertex_shade_tb;

    localparam int NW = 16;
    localparam int LATENCY = 303;

    typedef struct packed {
        logic [15:0] intensity;
        logic        faces_light;
    } shade_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [bpvs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bpvs_pkg::GAIN_W-1:0]    cfg_data;

    logic [15:0] ambient_q;
    logic [15:0] diffuse_q;
    logic [15:0] specular_q;
    logic [7:0]  shine_q;

    shade_t shade_q[$];
    int     mismatches;
    bit     idle_en;
    int     hold_cycles;

    blinn_phong_vertex_shade u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("blinn_phong_vertex_shade_tb failed");
        $finish;
    end

    function automatic longint unsigned sq_mag(logic [NW-1:0] v);
        longint unsigned m;
        m = v[NW-1] ? longint'((1 << NW) - v) : longint'(v);
        return m * m;
    endfunction

    function automatic shade_t shade_vertex(logic [NW-1:0] nx, logic [NW-1:0] ny,
                                            logic [NW-1:0] nz);
        shade_t r;
        longint unsigned sz, tot, q, rem, rt, b;
        int unsigned c, p, sum;
        sz = sq_mag(nz);
        sum = ambient_q;
        r.faces_light = !nz[NW-1] && nz != 0;
        if (r.faces_light)
        begin
            tot = sq_mag(nx) + sq_mag(ny) + sz;
            q = (sz >= tot) ? (64'd1 << 28) : ((sz << 28) / tot);
            rt = 0;
            rem = q;
            b = 64'd1 << 30;
            while (b > rem)
                b >>= 2;
            while (b != 0)
            begin
                if (rem >= rt + b)
                begin
                    rem -= rt + b;
                    rt = (rt >> 1) + b;
                end
                else
                    rt >>= 1;
                b >>= 2;
            end
            c = rt;
            p = 16384;
            for (int i = 0; i < shine_q; i++)
                p = (p * c + 8192) >> 14;
            sum += (diffuse_q * c + 8192) >> 14;
            sum += (specular_q * p + 8192) >> 14;
            if (sum > 65535)
                sum = 65535;
        end
        r.intensity = sum[15:0];
        return r;
    endfunction

    task automatic write_reg(logic [bpvs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            bpvs_pkg::REG_AMBIENT:  ambient_q  = val;
            bpvs_pkg::REG_DIFFUSE:  diffuse_q  = val;
            bpvs_pkg::REG_SPECULAR: specular_q = val;
            bpvs_pkg::REG_SHINE:    shine_q    = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (shade_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic set_regs(logic [15:0] a, logic [15:0] d, logic [15:0] s, logic [7:0] e);
        drain();
        write_reg(bpvs_pkg::REG_AMBIENT, a);
        write_reg(bpvs_pkg::REG_DIFFUSE, d);
        write_reg(bpvs_pkg::REG_SPECULAR, s);
        write_reg(bpvs_pkg::REG_SHINE, {$urandom_range(0, 255), e} & 16'hffff);
        cfg_we <= 1'b0;
    endtask

    task automatic send_vertex(logic [NW-1:0] nx, logic [NW-1:0] ny, logic [NW-1:0] nz);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {nz, ny, nx};
        do
            @(posedge clk);
        while (!s_tready);
        shade_q.push_back(shade_vertex(nx, ny, nz));
    endtask

    function automatic logic [NW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(signed'($urandom_range(0, 8)) - 4);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed;
        send_vertex(0, 0, 16'h1000);
        send_vertex(0, 0, 16'h7fff);
        send_vertex(0, 0, 16'h0001);
        send_vertex(16'h7fff, 16'h7fff, 16'h0001);
        send_vertex(16'h8000, 16'h8000, 16'h0001);
        send_vertex(16'h1234, 16'h8000, 0);
        send_vertex(16'h1234, 16'h4321, 16'h8000);
        send_vertex(16'hffff, 16'h0001, 16'hffff);
        send_vertex(16'h1000, 16'h1000, 16'h1000);
        send_vertex(16'h8000, 0, 16'h7fff);
        send_vertex(16'h0800, 16'hf800, 16'h0fff);
        send_vertex(0, 0, 0);
    endtask

    task automatic test_extremes;
        set_regs(16'hffff, 16'hffff, 16'hffff, 8'd0);
        test_directed();
        set_regs(16'h0000, 16'h0000, 16'h0000, 8'd255);
        test_directed();
        set_regs(16'h0000, 16'h4000, 16'h4000, 8'd1);
        test_directed();
        set_regs(16'h0000, 16'h3333, 16'hffff, 8'd0);
        send_vertex(16'h7fff, 16'h7fff, 16'h0001);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_vertex(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic test_backpressure;
        drain();
        hold_cycles = 400;
        for (int i = 0; i < 350; i++)
            send_vertex($urandom(), $urandom(), $urandom());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        mismatches = 0;
        idle_en   = 1'b1;
        hold_cycles = 0;
        ambient_q  = bpvs_pkg::AMBIENT_RST;
        diffuse_q  = bpvs_pkg::DIFFUSE_RST;
        specular_q = bpvs_pkg::SPECULAR_RST;
        shine_q    = bpvs_pkg::SHINE_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extremes();
        for (int ph = 0; ph < 4; ph++)
        begin
            set_regs($urandom(), $urandom(), $urandom(), $urandom());
            test_random(300);
        end
        test_backpressure();
        set_regs(bpvs_pkg::AMBIENT_RST, bpvs_pkg::DIFFUSE_RST, bpvs_pkg::SPECULAR_RST,
                 bpvs_pkg::SHINE_RST);
        idle_en = 1'b0;
        test_random(200);
        drain();
        if (mismatches == 0)
            $display("blinn_phong_vertex_shade_tb passed");
        else
            $display("blinn_phong_vertex_shade_tb failed");
        $finish;
    end

    // receiver stalls
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold = hold_cycles;
                hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // result check
    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (shade_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: intensity %0d faces %0b", m_tdata, m_tuser);
            end
            else
            begin
                want = shade_q.pop_front();
                if (want.intensity !== m_tdata || want.faces_light !== m_tuser)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0b got %0d/%0b", want.intensity,
                                 want.faces_light, m_tdata, m_tuser);
                end
            end
        end
    end

endmodule
